[hw/rtl/ack_retransmit_slot_tracker_unit_assert.svh]
// Assertion helpers for the tracker top module.
`ifndef ACK_RETRANSMIT_SLOT_TRACKER_UNIT_ASSERT_SVH
`define ACK_RETRANSMIT_SLOT_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARSTK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ARSTK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[hw/rtl/arstk_pkg.sv]
package arstk_pkg;

    localparam int MAX_PAYLOAD = 250;
    localparam int SEQ_BYTES   = 2;
    localparam int LEN_MAX     = MAX_PAYLOAD - SEQ_BYTES;

    localparam logic [31:0] TIMEOUT_DEFAULT = 32'd20000;
    localparam logic [7:0]  RETRIES_DEFAULT = 8'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [1:0] CFG_LINK_READY  = 2'd2;

    // Opcodes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SEND = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;
    localparam logic [1:0] OP_STAT = 2'd3;

    // Result event codes.
    localparam logic [3:0] EV_RETX       = 4'd0;
    localparam logic [3:0] EV_GIVE_UP    = 4'd1;
    localparam logic [3:0] EV_QUEUED     = 4'd2;
    localparam logic [3:0] EV_UNRELIABLE = 4'd3;
    localparam logic [3:0] EV_FAIL       = 4'd4;
    localparam logic [3:0] EV_BAD_LEN    = 4'd5;
    localparam logic [3:0] EV_NOT_READY  = 4'd6;
    localparam logic [3:0] EV_ACK_HIT    = 4'd7;
    localparam logic [3:0] EV_ACK_MISS   = 4'd8;
    localparam logic [3:0] EV_TICK_DONE  = 4'd9;
    localparam logic [3:0] EV_STAT       = 4'd10;

    // Statistics counter indexes.
    localparam int NSTATS         = 9;
    localparam int ST_ENQ_ATTEMPT = 0;
    localparam int ST_ENQ_OK      = 1;
    localparam int ST_DEQUEUE     = 2;
    localparam int ST_SEND_CALLS  = 3;
    localparam int ST_SEND_OK     = 4;
    localparam int ST_SEND_FAIL   = 5;
    localparam int ST_RETRIES     = 6;
    localparam int ST_ACK_OK      = 7;
    localparam int ST_ACK_TIMEOUT = 8;

    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] sent_time;
        logic [7:0]  retries;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [31:0] ack_timeout;
        logic [7:0]  max_retries;
        logic        link_ready;
    } t_cfg;

    typedef struct packed {
        logic [NSTATS-1:0] inc;
        logic [3:0]        sel;
    } t_stat_req;

    typedef struct packed {
        logic        valid;
        logic [3:0]  event_res;
        logic [2:0]  slot_index;
        logic [15:0] seq;
        logic [31:0] stat_value;
        logic        last;
    } t_evt;

endpackage

[hw/rtl/arstk_in_if.sv]
interface arstk_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] now_time;
    logic [15:0] ack_seq;
    logic [7:0]  payload_len;
    logic        inject_ok;
    logic [3:0]  stat_select;

    modport source (
        output valid, opcode, now_time, ack_seq, payload_len, inject_ok, stat_select,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_time, ack_seq, payload_len, inject_ok, stat_select,
        output ready
    );
endinterface

[hw/rtl/arstk_out_if.sv]
interface arstk_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [2:0]  slot_index;
    logic [15:0] seq;
    logic [31:0] stat_value;
    logic        last;

    modport source (
        output valid, event_res, slot_index, seq, stat_value, last,
        input  ready
    );
    modport sink (
        input  valid, event_res, slot_index, seq, stat_value, last,
        output ready
    );
endinterface

[hw/rtl/arstk_ram.sv]
module arstk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/arstk_stats.sv]
module arstk_stats (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  arstk_pkg::t_stat_req i_req,
    output logic [31:0]          o_value
);
    import arstk_pkg::*;

    logic [31:0] r_cnt [NSTATS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTATS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NSTATS; k++) begin
                r_cnt[k] <= r_cnt[k] + {31'd0, i_req.inc[k]};
            end
        end
    end

    // Selects past the last counter read as zero.
    assign o_value = (i_req.sel < 4'(NSTATS)) ? r_cnt[i_req.sel] : '0;

endmodule

[hw/rtl/arstk_ctrl.sv]
module arstk_ctrl #(
    parameter int SLOTS = 8,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    arstk_in_if.sink                 i_in,
    input  arstk_pkg::t_cfg          i_cfg,
    input  logic                     i_out_free,
    output arstk_pkg::t_evt          o_evt,
    output arstk_pkg::t_stat_req     o_stat_req,
    input  logic [31:0]              i_stat_value,
    output logic                     o_ram_we,
    output logic [IW-1:0]            o_ram_waddr,
    output logic [arstk_pkg::ENTRY_W-1:0] o_ram_wdata,
    output logic                     o_ram_re,
    output logic [IW-1:0]            o_ram_raddr,
    input  logic [arstk_pkg::ENTRY_W-1:0] i_ram_rdata
);
    import arstk_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DISP    = 3'd1;
    localparam logic [2:0] S_SCAN_RD = 3'd2;
    localparam logic [2:0] S_SCAN_EV = 3'd3;
    localparam logic [2:0] S_FIN     = 3'd4;
    localparam logic [2:0] S_ACK_RD  = 3'd5;
    localparam logic [2:0] S_ACK_CHK = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_free_found, n_free_found;
    logic [IW-1:0]    r_free_idx, n_free_idx;
    logic [15:0]      r_next_seq, n_next_seq;
    logic [SLOTS-1:0] r_busy, n_busy;

    logic [1:0]  r_op;
    logic [31:0] r_now;
    logic [15:0] r_ack_seq;
    logic [7:0]  r_len;
    logic        r_inj;
    logic [3:0]  r_sel;

    logic          w_accept;
    logic [IW-1:0] w_slot;
    logic          w_at_end;
    logic          w_bad_len;
    logic [15:0]   w_seq_new;
    logic [31:0]   w_age;
    logic          w_expired;
    t_entry        w_rd;
    t_entry        w_wr;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_slot    = r_idx[IW-1:0];
    assign w_at_end  = (r_idx == CW'(SLOTS));
    assign w_bad_len = (r_len == 8'd0) || (r_len > 8'(LEN_MAX));
    assign w_seq_new = r_next_seq + 16'd1;
    assign w_rd      = t_entry'(i_ram_rdata);
    assign w_age     = r_now - w_rd.sent_time;
    assign w_expired = (w_age >= i_cfg.ack_timeout);

    assign o_ram_wdata = ENTRY_W'(w_wr);
    assign o_ram_raddr = w_slot;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_next_seq   = r_next_seq;
        n_busy       = r_busy;
        o_ram_we     = 1'b0;
        o_ram_waddr  = w_slot;
        o_ram_re     = 1'b0;
        w_wr         = '0;
        o_evt        = '0;
        o_stat_req.inc = '0;
        o_stat_req.sel = r_sel;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_idx        = '0;
                n_free_found = 1'b0;
                unique case (r_op)
                    OP_TICK: begin
                        n_state = S_SCAN_RD;
                    end
                    OP_SEND: begin
                        if (w_bad_len) begin
                            if (i_out_free) begin
                                o_evt.valid     = 1'b1;
                                o_evt.event_res = EV_BAD_LEN;
                                o_evt.last      = 1'b1;
                                n_state         = S_IDLE;
                            end
                        end else if (!i_cfg.link_ready) begin
                            if (i_out_free) begin
                                o_stat_req.inc[ST_ENQ_ATTEMPT] = 1'b1;
                                o_evt.valid     = 1'b1;
                                o_evt.event_res = EV_NOT_READY;
                                o_evt.last      = 1'b1;
                                n_state         = S_IDLE;
                            end
                        end else begin
                            o_stat_req.inc[ST_ENQ_ATTEMPT] = 1'b1;
                            n_state = S_SCAN_RD;
                        end
                    end
                    OP_ACK: begin
                        n_state = S_ACK_RD;
                    end
                    OP_STAT: begin
                        if (i_out_free) begin
                            o_evt.valid      = 1'b1;
                            o_evt.event_res  = EV_STAT;
                            o_evt.stat_value = i_stat_value;
                            o_evt.last       = 1'b1;
                            n_state          = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN_RD: begin
                if (w_at_end) begin
                    n_state = S_FIN;
                end else if (r_busy[w_slot]) begin
                    o_ram_re = 1'b1;
                    n_state  = S_SCAN_EV;
                end else begin
                    if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = w_slot;
                    end
                    n_idx = r_idx + CW'(1);
                end
            end
            S_SCAN_EV: begin
                if (!w_expired) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SCAN_RD;
                end else if (i_out_free) begin
                    o_evt.valid      = 1'b1;
                    o_evt.slot_index = 3'(w_slot);
                    o_evt.seq        = w_rd.seq;
                    if (w_rd.retries != 8'd0) begin
                        w_wr.seq        = w_rd.seq;
                        w_wr.sent_time  = r_now;
                        w_wr.retries    = w_rd.retries - 8'd1;
                        o_ram_we        = 1'b1;
                        o_stat_req.inc[ST_RETRIES]    = 1'b1;
                        o_stat_req.inc[ST_SEND_CALLS] = 1'b1;
                        o_evt.event_res = EV_RETX;
                    end else begin
                        n_busy[w_slot]  = 1'b0;
                        o_stat_req.inc[ST_ACK_TIMEOUT] = 1'b1;
                        o_evt.event_res = EV_GIVE_UP;
                        if (!r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = w_slot;
                        end
                    end
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_evt.valid = 1'b1;
                    o_evt.last  = 1'b1;
                    n_state     = S_IDLE;
                    unique case (r_op)
                        OP_SEND: begin
                            n_next_seq = w_seq_new;
                            o_evt.seq  = w_seq_new;
                            o_stat_req.inc[ST_ENQ_OK]     = 1'b1;
                            o_stat_req.inc[ST_DEQUEUE]    = 1'b1;
                            o_stat_req.inc[ST_SEND_CALLS] = 1'b1;
                            if (!r_free_found) begin
                                o_stat_req.inc[ST_SEND_OK]     = 1'b1;
                                o_stat_req.inc[ST_ACK_TIMEOUT] = 1'b1;
                                o_evt.event_res = EV_UNRELIABLE;
                            end else if (!r_inj) begin
                                o_stat_req.inc[ST_SEND_FAIL] = 1'b1;
                                o_evt.event_res  = EV_FAIL;
                                o_evt.slot_index = 3'(r_free_idx);
                            end else begin
                                w_wr.seq       = w_seq_new;
                                w_wr.sent_time = r_now;
                                w_wr.retries   = i_cfg.max_retries;
                                o_ram_we       = 1'b1;
                                o_ram_waddr    = r_free_idx;
                                n_busy[r_free_idx] = 1'b1;
                                o_stat_req.inc[ST_SEND_OK] = 1'b1;
                                o_evt.event_res  = EV_QUEUED;
                                o_evt.slot_index = 3'(r_free_idx);
                            end
                        end
                        OP_ACK: begin
                            o_evt.event_res = EV_ACK_MISS;
                            o_evt.seq       = r_ack_seq;
                        end
                        default: begin
                            o_evt.event_res = EV_TICK_DONE;
                        end
                    endcase
                end
            end
            S_ACK_RD: begin
                if (w_at_end) begin
                    n_state = S_FIN;
                end else if (r_busy[w_slot]) begin
                    o_ram_re = 1'b1;
                    n_state  = S_ACK_CHK;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_ACK_CHK: begin
                if (w_rd.seq != r_ack_seq) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_ACK_RD;
                end else if (i_out_free) begin
                    n_busy[w_slot] = 1'b0;
                    o_stat_req.inc[ST_ACK_OK] = 1'b1;
                    o_evt.valid      = 1'b1;
                    o_evt.event_res  = EV_ACK_HIT;
                    o_evt.slot_index = 3'(w_slot);
                    o_evt.seq        = r_ack_seq;
                    o_evt.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_free_found <= 1'b0;
            r_next_seq   <= '0;
            r_busy       <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_free_found <= n_free_found;
            r_next_seq   <= n_next_seq;
            r_busy       <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        if (w_accept) begin
            r_op      <= i_in.opcode;
            r_now     <= i_in.now_time;
            r_ack_seq <= i_in.ack_seq;
            r_len     <= i_in.payload_len;
            r_inj     <= i_in.inject_ok;
            r_sel     <= i_in.stat_select;
        end
    end

endmodule

[hw/rtl/ack_retransmit_slot_tracker_unit.sv]
// Retransmission timer table for frames awaiting acknowledgment.
// Input channel i_in carries one command per beat: tick, reliable send,
// acknowledgment or statistics read. Output channel o_out returns one or
// more result beats per command; the final beat of a command has last set.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data).
// Configuration must be written by the user only while no command is in
// flight; the block does not enforce this. A command is taken only while
// the sequencer is idle; it then runs to completion before the next is
// accepted. A tick or an accepted send visits every slot in the entry RAM;
// each busy slot is read through the entry RAM's single read port before
// it is judged. An acknowledgment stops at the first matching slot.
// Results go through one output register; while the receiver stalls the
// sequencer holds its place, and the next command may be accepted while
// the last beat of the previous one still waits in that register.
// Reset clears the busy bits, the counters, the sequence number and loads
// the register defaults; slot contents need no clearing pass.
module ack_retransmit_slot_tracker_unit #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    arstk_in_if.sink    i_in,
    arstk_out_if.source o_out
);
    import arstk_pkg::*;
    `include "ack_retransmit_slot_tracker_unit_assert.svh"

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [31:0] r_ack_timeout;
    logic [7:0]  r_max_retries;
    logic        r_link_ready;
    t_cfg        w_cfg;

    logic        r_out_valid;
    logic [3:0]  r_out_event;
    logic [2:0]  r_out_slot;
    logic [15:0] r_out_seq;
    logic [31:0] r_out_stat;
    logic        r_out_last;
    logic        w_out_free;

    t_evt         w_evt;
    t_stat_req    w_stat_req;
    logic [31:0]  w_stat_value;

    logic               w_ram_we;
    logic [IW-1:0]      w_ram_waddr;
    logic [ENTRY_W-1:0] w_ram_wdata;
    logic               w_ram_re;
    logic [IW-1:0]      w_ram_raddr;
    logic [ENTRY_W-1:0] w_ram_rdata;

    // A zero timeout would make every busy slot expire, so it loads the default.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= TIMEOUT_DEFAULT;
            r_max_retries <= RETRIES_DEFAULT;
            r_link_ready  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACK_TIMEOUT: begin
                    r_ack_timeout <= (i_cfg_data != 32'd0) ? i_cfg_data : TIMEOUT_DEFAULT;
                end
                CFG_MAX_RETRIES: r_max_retries <= i_cfg_data[7:0];
                CFG_LINK_READY:  r_link_ready  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_cfg.ack_timeout = r_ack_timeout;
    assign w_cfg.max_retries = r_max_retries;
    assign w_cfg.link_ready  = r_link_ready;

    // Output register: the sequencer only issues a beat when it can be loaded.
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_evt.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt.valid) begin
            r_out_event <= w_evt.event_res;
            r_out_slot  <= w_evt.slot_index;
            r_out_seq   <= w_evt.seq;
            r_out_stat  <= w_evt.stat_value;
            r_out_last  <= w_evt.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_res  = r_out_event;
    assign o_out.slot_index = r_out_slot;
    assign o_out.seq        = r_out_seq;
    assign o_out.stat_value = r_out_stat;
    assign o_out.last       = r_out_last;

    arstk_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (w_cfg),
        .i_out_free   (w_out_free),
        .o_evt        (w_evt),
        .o_stat_req   (w_stat_req),
        .i_stat_value (w_stat_value),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    // Slot entries: sequence number, send time and retries left.
    arstk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    arstk_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_stat_req),
        .o_value (w_stat_value)
    );

    `ARSTK_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, w_evt.valid, !r_out_valid || o_out.ready)
    `ARSTK_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `ARSTK_ASSERT_IMP(a_stat_only, i_clk, i_rst_n, r_out_valid && (r_out_event != EV_STAT), r_out_stat == 32'd0)
    `ARSTK_ASSERT_IMP(a_timeout_nonzero, i_clk, i_rst_n, 1'b1, r_ack_timeout != 32'd0)

endmodule

[tb/sv/retx_table_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the slot tracker. It keeps a table model of its own
// to work out the result beats of each accepted command, and compares each
// result beat with the oldest one still due.
module retx_table_checker
    import arstk_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    arstk_in_if         i_cmd,
    arstk_out_if        i_res,
    output int          o_fail_count,
    output int          o_pending
);

    logic        tbl_busy  [SLOTS];
    logic [15:0] tbl_seq   [SLOTS];
    logic [31:0] tbl_stamp [SLOTS];
    logic [7:0]  tbl_tries [SLOTS];
    logic [15:0] seq_counter;
    logic [31:0] counters [NSTATS];
    logic [31:0] cfg_timeout;
    logic [7:0]  cfg_retries;
    logic        cfg_link;
    t_evt        due_events [$];
    int          fails = 0;

    assign o_fail_count = fails;

    task automatic expect_beat(input logic [3:0] ev, input int slot, input logic [15:0] seq,
                               input logic [31:0] value);
        t_evt b;
        b.valid      = 1'b1;
        b.event_res  = ev;
        b.slot_index = 3'(slot);
        b.seq        = seq;
        b.stat_value = value;
        b.last       = 1'b0;
        due_events.push_back(b);
    endtask

    // Retransmit or retire every busy slot whose age has reached the timeout.
    task automatic scan_expired(input logic [31:0] now);
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_busy[i] && (now - tbl_stamp[i]) >= cfg_timeout) begin
                if (tbl_tries[i] != 8'd0) begin
                    counters[ST_RETRIES]++;
                    counters[ST_SEND_CALLS]++;
                    tbl_stamp[i] = now;
                    tbl_tries[i]--;
                    expect_beat(EV_RETX, i, tbl_seq[i], 32'd0);
                end else begin
                    tbl_busy[i] = 1'b0;
                    counters[ST_ACK_TIMEOUT]++;
                    expect_beat(EV_GIVE_UP, i, tbl_seq[i], 32'd0);
                end
            end
        end
    endtask

    task automatic apply_command(input logic [1:0] op, input logic [31:0] now,
                                 input logic [15:0] aseq, input logic [7:0] len,
                                 input logic inj, input logic [3:0] sel);
        int   free_slot;
        int   hit;
        t_evt final_beat;
        case (op)
            OP_TICK: begin
                scan_expired(now);
                expect_beat(EV_TICK_DONE, 0, 16'd0, 32'd0);
            end
            OP_SEND: begin
                if (len == 8'd0 || len > LEN_MAX) begin
                    expect_beat(EV_BAD_LEN, 0, 16'd0, 32'd0);
                end else begin
                    counters[ST_ENQ_ATTEMPT]++;
                    if (!cfg_link) begin
                        expect_beat(EV_NOT_READY, 0, 16'd0, 32'd0);
                    end else begin
                        scan_expired(now);
                        free_slot = -1;
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!tbl_busy[i])
                                free_slot = i;
                        counters[ST_ENQ_OK]++;
                        counters[ST_DEQUEUE]++;
                        counters[ST_SEND_CALLS]++;
                        seq_counter++;
                        if (free_slot < 0) begin
                            counters[ST_SEND_OK]++;
                            counters[ST_ACK_TIMEOUT]++;
                            expect_beat(EV_UNRELIABLE, 0, seq_counter, 32'd0);
                        end else if (!inj) begin
                            counters[ST_SEND_FAIL]++;
                            expect_beat(EV_FAIL, free_slot, seq_counter, 32'd0);
                        end else begin
                            tbl_busy[free_slot]  = 1'b1;
                            tbl_seq[free_slot]   = seq_counter;
                            tbl_stamp[free_slot] = now;
                            tbl_tries[free_slot] = cfg_retries;
                            counters[ST_SEND_OK]++;
                            expect_beat(EV_QUEUED, free_slot, seq_counter, 32'd0);
                        end
                    end
                end
            end
            OP_ACK: begin
                hit = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tbl_busy[i] && tbl_seq[i] == aseq)
                        hit = i;
                if (hit >= 0) begin
                    tbl_busy[hit] = 1'b0;
                    counters[ST_ACK_OK]++;
                    expect_beat(EV_ACK_HIT, hit, aseq, 32'd0);
                end else begin
                    expect_beat(EV_ACK_MISS, 0, aseq, 32'd0);
                end
            end
            OP_STAT: begin
                expect_beat(EV_STAT, 0, 16'd0, (sel < NSTATS) ? counters[sel] : 32'd0);
            end
        endcase
        final_beat = due_events.pop_back();
        final_beat.last = 1'b1;
        due_events.push_back(final_beat);
    endtask

    task automatic check_beat(input t_evt got);
        t_evt want;
        if (due_events.size() == 0) begin
            if (fails < 10)
                $display("%0t: result beat with nothing due: ev=%0d slot=%0d seq=%0d stat=%0d",
                         $time, got.event_res, got.slot_index, got.seq, got.stat_value);
            fails++;
        end else begin
            want = due_events.pop_front();
            if (got.event_res !== want.event_res || got.slot_index !== want.slot_index ||
                got.seq !== want.seq || got.stat_value !== want.stat_value ||
                got.last !== want.last) begin
                if (fails < 10) begin
                    $display("%0t: result beat mismatch", $time);
                    $display("  expected ev=%0d slot=%0d seq=%0d stat=%0d last=%0d",
                             want.event_res, want.slot_index, want.seq, want.stat_value,
                             want.last);
                    $display("  actual   ev=%0d slot=%0d seq=%0d stat=%0d last=%0d",
                             got.event_res, got.slot_index, got.seq, got.stat_value, got.last);
                end
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                tbl_busy[i]  = 1'b0;
                tbl_seq[i]   = 16'd0;
                tbl_stamp[i] = 32'd0;
                tbl_tries[i] = 8'd0;
            end
            for (int i = 0; i < NSTATS; i++)
                counters[i] = 32'd0;
            seq_counter = 16'd0;
            cfg_timeout = TIMEOUT_DEFAULT;
            cfg_retries = RETRIES_DEFAULT;
            cfg_link    = 1'b0;
            due_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACK_TIMEOUT: cfg_timeout = (i_cfg_data == 32'd0) ? TIMEOUT_DEFAULT
                                                                         : i_cfg_data;
                    CFG_MAX_RETRIES: cfg_retries = i_cfg_data[7:0];
                    CFG_LINK_READY:  cfg_link = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready)
                check_beat('{valid: 1'b1, event_res: i_res.event_res,
                             slot_index: i_res.slot_index, seq: i_res.seq,
                             stat_value: i_res.stat_value, last: i_res.last});
            if (i_cmd.valid && i_cmd.ready)
                apply_command(i_cmd.opcode, i_cmd.now_time, i_cmd.ack_seq, i_cmd.payload_len,
                              i_cmd.inject_ok, i_cmd.stat_select);
        end
        o_pending <= due_events.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

// Top of the slot tracker bench. This module only makes stimulus and gives the
// verdict; the checker beside the block predicts every result beat and counts
// failures. Commands change on the falling clock edge, and every handshake is
// judged at the rising edge.
module testbench;
    import arstk_pkg::*;

    localparam int SLOTS       = 8;
    // Cycles without any accepted beat before the run is declared hung. The
    // longest legal gap is the deliberate receiver hold-off plus one full scan,
    // so this leaves a wide margin.
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    // Extra wait after the last due beat, to cover any work still in flight.
    localparam int SETTLE      = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;

    // Knobs for the sender and the receiver, and the watchdog's quiet count.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_len      = 0;
    int          quiet_cycles  = 0;

    // What the stimulus needs to know of the block: the settings in force, the
    // running time stamp and the last sequence number handed out.
    logic [31:0] cur_timeout = TIMEOUT_DEFAULT;
    logic        cur_link    = 1'b0;
    logic [31:0] now_us      = 32'd0;
    logic [15:0] last_seq    = 16'd0;

    arstk_in_if  cmd_ch ();
    arstk_out_if res_ch ();

    ack_retransmit_slot_tracker_unit #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (cmd_ch),
        .o_out     (res_ch)
    );

    retx_table_checker #(
        .SLOTS(SLOTS)
    ) tracker_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_cmd       (cmd_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offers one command beat, after a random number of idle cycles, and
    // returns on the falling edge after it was taken. Valid stays high on
    // return, so back-to-back beats leave no gap.
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] now,
                            input logic [15:0] aseq, input logic [7:0] len,
                            input logic inj, input logic [3:0] sel);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.now_time    <= now;
        cmd_ch.ack_seq     <= aseq;
        cmd_ch.payload_len <= len;
        cmd_ch.inject_ok   <= inj;
        cmd_ch.stat_select <= sel;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        // A send of legal length on an open link always consumes a number.
        if (op == OP_SEND && len != 8'd0 && len <= LEN_MAX && cur_link)
            last_seq++;
    endtask

    // The fields a command does not use are filled with noise.
    task automatic do_send(input logic [7:0] len, input logic inj, input logic [31:0] now);
        send_cmd(OP_SEND, now, 16'($urandom), len, inj, 4'($urandom));
    endtask

    task automatic do_tick(input logic [31:0] now);
        send_cmd(OP_TICK, now, 16'($urandom), 8'($urandom), 1'($urandom), 4'($urandom));
    endtask

    task automatic do_ack(input logic [15:0] aseq);
        send_cmd(OP_ACK, $urandom, aseq, 8'($urandom), 1'($urandom), 4'($urandom));
    endtask

    task automatic do_stat(input logic [3:0] sel);
        send_cmd(OP_STAT, $urandom, 16'($urandom), 8'($urandom), 1'($urandom), sel);
    endtask

    // Stops offering commands until every result beat due has been taken,
    // then lets the block finish whatever it may still be doing.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
    endtask

    // Registers are only written with the block idle, so settle first.
    task automatic set_config(input logic [31:0] timeout, input logic [7:0] retries,
                              input logic link);
        settle();
        write_reg(CFG_ACK_TIMEOUT, timeout);
        write_reg(CFG_MAX_RETRIES, {24'd0, retries});
        write_reg(CFG_LINK_READY, {31'd0, link});
        cfg_we <= 1'b0;
        cur_timeout = (timeout == 32'd0) ? TIMEOUT_DEFAULT : timeout;
        cur_link    = link;
    endtask

    // One random command. Time mostly creeps forward by a fraction of the
    // timeout so slots expire after a few commands; now and then it jumps to
    // any value, which also exercises the modulo age. Most acks name a recent
    // sequence number so that they actually hit a busy slot.
    task automatic random_item();
        int unsigned pick;
        logic [31:0] span;
        logic [7:0]  len;
        pick = $urandom_range(99);
        span = cur_timeout / 3 + 1;
        if ($urandom_range(19) == 0)
            now_us = $urandom;
        else
            now_us = now_us + $urandom_range(span);
        if (pick < 42) begin
            if ($urandom_range(9) != 0)
                len = 8'($urandom_range(1, LEN_MAX));
            else if ($urandom_range(2) == 0)
                len = 8'd0;
            else
                len = 8'($urandom_range(LEN_MAX + 1, 255));
            do_send(len, $urandom_range(7) != 0, now_us);
        end else if (pick < 66) begin
            do_tick(now_us);
        end else if (pick < 90) begin
            if ($urandom_range(4) == 0)
                do_ack(16'($urandom));
            else
                do_ack(16'(last_seq - $urandom_range(9)));
        end else begin
            do_stat(4'($urandom_range(15)));
        end
    endtask

    // Receiver: takes result beats with a random stall rate, or holds off for
    // a long stretch when asked, counting the cycles itself.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold_len) @(negedge i_clk);
                hold_len = 0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Cycles since the last beat was accepted on either channel.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [31:0] tmo;
        logic [7:0]  tries;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_ACK_TIMEOUT;
        cfg_data           = 32'd0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = OP_TICK;
        cmd_ch.now_time    = 32'd0;
        cmd_ch.ack_seq     = 16'd0;
        cmd_ch.payload_len = 8'd0;
        cmd_ch.inject_ok   = 1'b0;
        cmd_ch.stat_select = 4'd0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_config(TIMEOUT_DEFAULT, RETRIES_DEFAULT, 1'b1);

        // Directed part. Counter reads, including selects past the last one.
        do_stat(4'(ST_SEND_CALLS));
        do_stat(4'(NSTATS));
        do_stat(4'hF);
        // Two sends land in slots 0 and 1, at the shortest and longest legal
        // lengths.
        do_send(8'd1, 1'b1, 32'd0);
        do_send(8'(LEN_MAX), 1'b1, 32'd100);
        // Lengths of zero and just past the limit are refused untouched.
        do_send(8'd0, 1'b1, 32'd100);
        do_send(8'(LEN_MAX + 1), 1'b1, 32'd100);
        do_send(8'hFF, 1'b1, 32'd100);
        // Slot 0 has aged exactly one timeout and goes out again; slot 1 not.
        do_tick(32'd20000);
        // An ack hit on the newest number, then the same number again as a miss.
        do_ack(last_seq);
        do_ack(last_seq);
        // First transmission fails: the number is spent, slot 1 stays free.
        do_send(8'd10, 1'b0, 32'd20100);

        // Zero timeout falls back to the default; with the link closed a send
        // is turned away but a tick still scans.
        set_config(32'd0, 8'd0, 1'b0);
        do_send(8'd5, 1'b1, 32'd20100);
        do_tick(32'd60000);

        // Shortest timeout: the send retransmits slot 0 on its way in, then
        // the tick retires both slots with no retries left.
        set_config(32'd1, 8'd0, 1'b1);
        do_send(8'd5, 1'b1, 32'd60001);
        do_tick(32'd60002);

        // Fill every slot, overflow into an unreliable send, then one tick
        // that retransmits all of them for the longest burst of results.
        set_config(32'd1, 8'd255, 1'b1);
        repeat (SLOTS + 1) do_send(8'd20, 1'b1, 32'd70000);
        do_tick(32'd69999);

        // Longest timeout: only an age of all ones reaches it.
        set_config(32'hFFFF_FFFF, RETRIES_DEFAULT, 1'b1);
        do_tick(32'd69998);

        // Random part: receiver idles more than sender, then the reverse, then
        // neither. Each half of a phase runs under fresh settings.
        now_us = 32'd70000;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 18 : 0;
            for (int part = 0; part < 2; part++) begin
                case ($urandom_range(4))
                    0: tmo = 32'($urandom_range(1, 50));
                    1: tmo = 32'($urandom_range(100, 5000));
                    2: tmo = 32'd0;
                    3: tmo = TIMEOUT_DEFAULT;
                    default: tmo = $urandom;
                endcase
                case ($urandom_range(4))
                    0: tries = 8'd0;
                    1: tries = 8'd1;
                    2: tries = RETRIES_DEFAULT;
                    3: tries = 8'hFF;
                    default: tries = 8'($urandom);
                endcase
                set_config(tmo, tries, $urandom_range(7) != 0);
                repeat (50) random_item();
                // The receiver stops for a long stretch while commands keep
                // coming, so the block backs up and stalls its input.
                if (phase == 2 && part == 0) begin
                    hold_len = HOLD_CYCLES;
                    repeat (40) random_item();
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
